>>> design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define QSFP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same, on the block clock and reset.
`define QSFP_ASSERT(label, prop, msg) `QSFP_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

>>> design/qsfp_pkg.sv
`default_nettype none

package qsfp_pkg;

    // Geometry
    localparam int STATE_SIZE = 10;
    localparam int COEFS_PER  = 1 + STATE_SIZE + STATE_SIZE * STATE_SIZE;
    localparam int MEM_DEPTH  = 2 * COEFS_PER;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int IDX_W      = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;

    // Field widths
    localparam int KIND_W    = 1;
    localparam int CIDX_W    = 7;
    localparam int ELEM_W    = 4;
    localparam int VAL_W     = 32;
    localparam int DRIVE_W   = 16;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;

    // Arithmetic
    localparam int PROD_W = 2 * VAL_W;
    localparam int FRAC   = 16;
    localparam int ACC_W  = 56;

    localparam logic [ELEM_W-1:0] LAST_ELEM = ELEM_W'(STATE_SIZE - 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(STATE_SIZE - 1);

    localparam logic signed [ACC_W-1:0] ACC_S32_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] ACC_S32_MIN = ACC_W'(-64'sd2147483648);
    localparam logic signed [ACC_W-1:0] ACC_ONE_Q14 = ACC_W'(64'sd16384);
    localparam logic signed [ACC_W-1:0] ACC_NEG_ONE = ACC_W'(-64'sd16384);
    localparam logic signed [DRIVE_W-1:0] DRIVE_ONE = 16'sd16384;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_COEF  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_STATE = 1'b1;

    // Policy forms
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AFFINE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd3;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_MODE  = 1'b1;

    // Datapath operations
    localparam logic [1:0] OP_LIN  = 2'd0;  // acc += c*x
    localparam logic [1:0] OP_BIAS = 2'd1;  // acc += c
    localparam logic [1:0] OP_ROW  = 2'd2;  // row += q*x
    localparam logic [1:0] OP_REND = 2'd3;  // acc += sat32(row)*x

    typedef struct packed {
        logic             valid;
        logic [1:0]       code;
        logic             first;
        logic [IDX_W-1:0] xidx;
    } t_op;

    typedef struct packed {
        logic capture;
        logic pol;
        logic zero;
    } t_cap;

    // Q16.16 total to saturated Q2.14
    function automatic logic [DRIVE_W-1:0] to_drive(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        logic signed [ACC_W-1:0] c;
        q = acc >>> 2;
        if (q > ACC_ONE_Q14) begin
            c = ACC_ONE_Q14;
        end else if (q < ACC_NEG_ONE) begin
            c = ACC_NEG_ONE;
        end else begin
            c = q;
        end
        return c[DRIVE_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/qsfp_coef_mem.sv
`default_nettype none

module qsfp_coef_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [qsfp_pkg::ADDR_W-1:0] i_wr_addr,
    input  wire logic [qsfp_pkg::VAL_W-1:0]  i_wr_data,
    input  wire logic [qsfp_pkg::ADDR_W-1:0] i_rd_addr,
    output logic      [qsfp_pkg::VAL_W-1:0]  o_rd_data
);
    import qsfp_pkg::*;

    logic [VAL_W-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    logic [VAL_W-1:0] r_rd_q;
    logic             r_rd_valid;

    // Written-entry flags; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // Storage array, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_valid ? r_rd_q : '0;

endmodule

`default_nettype wire

>>> design/qsfp_mac.sv
`default_nettype none

module qsfp_mac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire qsfp_pkg::t_op                     i_op,
    input  wire logic signed [qsfp_pkg::VAL_W-1:0] i_x,
    input  wire logic signed [qsfp_pkg::VAL_W-1:0] i_coef,
    output logic signed      [qsfp_pkg::ACC_W-1:0] o_acc,
    output logic                                   o_pipe_empty
);
    import qsfp_pkg::*;

    t_op                      r_s1_op;
    logic signed [VAL_W-1:0]  r_s1_x;
    t_op                      r_s2_op;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_row;

    logic signed [VAL_W-1:0]  row_sat;
    logic signed [VAL_W-1:0]  mul_a;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [ACC_W-1:0]  term;

    // Row sum clamped to the 32-bit Q16.16 range
    always_comb begin
        if (r_row > ACC_S32_MAX) begin
            row_sat = ACC_S32_MAX[VAL_W-1:0];
        end else if (r_row < ACC_S32_MIN) begin
            row_sat = ACC_S32_MIN[VAL_W-1:0];
        end else begin
            row_sat = r_row[VAL_W-1:0];
        end
    end

    // Stage 1: one multiply, or the bias placed at Q32.32
    always_comb begin
        mul_a = (r_s1_op.code == OP_REND) ? row_sat : i_coef;
        if (r_s1_op.code == OP_BIAS) begin
            n_prod = $signed({i_coef, {(PROD_W-VAL_W){1'b0}}}) >>> (VAL_W - FRAC);
        end else begin
            n_prod = mul_a * r_s1_x;
        end
    end

    // Stage 2: floor to Q16.16
    assign prod_sh = r_s2_prod >>> FRAC;
    assign term    = prod_sh[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_op.valid <= 1'b0;
            r_s2_op.valid <= 1'b0;
        end else begin
            r_s1_op.valid <= i_op.valid;
            r_s2_op.valid <= r_s1_op.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op.code  <= i_op.code;
        r_s1_op.first <= i_op.first;
        r_s1_op.xidx  <= i_op.xidx;
        r_s1_x        <= i_x;
        r_s2_op.code  <= r_s1_op.code;
        r_s2_op.first <= r_s1_op.first;
        r_s2_op.xidx  <= r_s1_op.xidx;
        r_s2_prod     <= n_prod;
        // Accumulate into the row or the policy total
        if (r_s2_op.valid) begin
            case (r_s2_op.code)
                OP_ROW:  r_row <= r_s2_op.first ? term : r_row + term;
                OP_LIN:  r_acc <= r_s2_op.first ? term : r_acc + term;
                default: r_acc <= r_acc + term;
            endcase
        end
    end

    assign o_acc        = r_acc;
    assign o_pipe_empty = !r_s1_op.valid && !r_s2_op.valid;

endmodule

`default_nettype wire

>>> design/qsfp_seq.sv
`default_nettype none

module qsfp_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_go,
    input  wire logic [qsfp_pkg::MODE_W-1:0] i_wheel_mode,
    input  wire logic [qsfp_pkg::MODE_W-1:0] i_turn_mode,
    input  wire logic                        i_pipe_empty,
    output logic                             o_busy,
    output qsfp_pkg::t_op                    o_op,
    output logic      [qsfp_pkg::ADDR_W-1:0] o_rd_addr,
    output qsfp_pkg::t_cap                   o_cap
);
    import qsfp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_LIN   = 3'd2;
    localparam logic [2:0] ST_BIAS  = 3'd3;
    localparam logic [2:0] ST_ROW   = 3'd4;
    localparam logic [2:0] ST_GAP   = 3'd5;
    localparam logic [2:0] ST_REND  = 3'd6;
    localparam logic [2:0] ST_DRAIN = 3'd7;

    logic [2:0]        r_state, n_state;
    logic              r_pol, n_pol;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [ADDR_W-1:0] r_addr, n_addr;

    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] base;

    assign mode = r_pol ? i_turn_mode : i_wheel_mode;
    assign base = r_pol ? ADDR_W'(COEFS_PER) : '0;

    // Issue order per policy, as far as its form goes: linear gains, bias, rows of Q each closed by x[i]
    always_comb begin
        n_state     = r_state;
        n_pol       = r_pol;
        n_i         = r_i;
        n_j         = r_j;
        n_addr      = r_addr;
        o_op        = '0;
        o_cap       = '0;
        o_cap.pol   = r_pol;
        unique case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    n_pol   = 1'b0;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (mode == MODE_NONE) begin
                    o_cap.capture = 1'b1;
                    o_cap.zero    = 1'b1;
                    if (r_pol) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pol = 1'b1;
                    end
                end else begin
                    n_state = ST_LIN;
                    n_j     = '0;
                    n_addr  = base + ADDR_W'(1);
                end
            end
            ST_LIN: begin
                o_op.valid = 1'b1;
                o_op.code  = OP_LIN;
                o_op.first = (r_j == '0);
                o_op.xidx  = r_j;
                n_addr     = r_addr + ADDR_W'(1);
                if (r_j == LAST_IDX) begin
                    n_j = '0;
                    if (mode == MODE_LINEAR) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_state = ST_BIAS;
                        n_addr  = base;
                    end
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            ST_BIAS: begin
                o_op.valid = 1'b1;
                o_op.code  = OP_BIAS;
                if (mode == MODE_QUAD) begin
                    n_state = ST_ROW;
                    n_i     = '0;
                    n_j     = '0;
                    n_addr  = base + ADDR_W'(1 + STATE_SIZE);
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_ROW: begin
                o_op.valid = 1'b1;
                o_op.code  = OP_ROW;
                o_op.first = (r_j == '0);
                o_op.xidx  = r_j;
                n_addr     = r_addr + ADDR_W'(1);
                if (r_j == LAST_IDX) begin
                    n_j     = '0;
                    n_state = ST_GAP;
                    // keep the read address inside the store after the last row
                    if (r_i == LAST_IDX) begin
                        n_addr = base;
                    end
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            // Row sum lands in the datapath before it is read back
            ST_GAP: begin
                n_state = ST_REND;
            end
            ST_REND: begin
                o_op.valid = 1'b1;
                o_op.code  = OP_REND;
                o_op.xidx  = r_i;
                if (r_i == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = ST_ROW;
                end
            end
            ST_DRAIN: begin
                if (i_pipe_empty) begin
                    o_cap.capture = 1'b1;
                    if (r_pol) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pol   = 1'b1;
                        n_state = ST_START;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pol   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_pol   <= n_pol;
            r_i     <= n_i;
            r_j     <= n_j;
            r_addr  <= n_addr;
        end
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_rd_addr = r_addr;

endmodule

`default_nettype wire

>>> design/quadratic_state_feedback_policy.sv
`default_nettype none

// Two state-feedback policies (wheel, turntable) on a STATE_SIZE-element state
// vector, Q16.16 in, saturated Q2.14 out. An item is taken when start is high
// and busy is low. Coefficient writes and state elements other than the last
// leave busy low. The last element (index STATE_SIZE-1) raises busy while the
// coefficients are streamed from the coefficient memory through one multiplier,
// one coefficient per cycle outside the row-sum turnaround and the final drain,
// since the memory has a single read port. busy drops in the cycle in which
// o_result_valid shows both drives for exactly one cycle; the receiver cannot
// stall, so the result must be taken then. Coefficients read as zero until
// written after reset. Configuration writes are always ready and belong in
// idle time only.
module quadratic_state_feedback_policy (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [qsfp_pkg::KIND_W-1:0]          i_kind,
    input  wire logic                                 i_target_policy,
    input  wire logic [qsfp_pkg::CIDX_W-1:0]          i_coef_index,
    input  wire logic [qsfp_pkg::ELEM_W-1:0]          i_element_index,
    input  wire logic signed [qsfp_pkg::VAL_W-1:0]    i_value,
    output logic                                      o_result_valid,
    output logic signed [qsfp_pkg::DRIVE_W-1:0]      o_wheel_drive,
    output logic signed [qsfp_pkg::DRIVE_W-1:0]      o_turntable_drive,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [qsfp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [qsfp_pkg::MODE_W-1:0]          i_cfg_data
);
    import qsfp_pkg::*;

    logic [MODE_W-1:0]       r_wheel_mode;
    logic [MODE_W-1:0]       r_turn_mode;
    logic signed [VAL_W-1:0] r_x [STATE_SIZE];
    logic                    r_result_valid;
    logic [DRIVE_W-1:0]      r_wheel_drive;
    logic [DRIVE_W-1:0]      r_turn_drive;

    logic                    accept;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    x_en;
    logic [IDX_W-1:0]        x_wr_idx;
    logic                    go;
    logic                    seq_busy;
    t_op                     op;
    t_cap                    cap;
    logic [ADDR_W-1:0]       rd_addr;
    logic [VAL_W-1:0]        coef;
    logic signed [VAL_W-1:0] x_val;
    logic signed [ACC_W-1:0] acc;
    logic                    pipe_empty;
    logic [DRIVE_W-1:0]      cap_drive;

    // Item decode
    assign accept   = start && !seq_busy;
    assign wr_en    = accept && (i_kind == KIND_COEF) && (int'(i_coef_index) < COEFS_PER);
    assign wr_addr  = (i_target_policy ? ADDR_W'(COEFS_PER) : '0) + ADDR_W'(i_coef_index);
    assign x_en     = accept && (i_kind == KIND_STATE)
                      && (int'(i_element_index) < STATE_SIZE);
    assign x_wr_idx = i_element_index[IDX_W-1:0];
    assign go       = x_en && (i_element_index == LAST_ELEM);

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_mode <= MODE_NONE;
            r_turn_mode  <= MODE_NONE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WHEEL_MODE: r_wheel_mode <= i_cfg_data;
                CFG_TURN_MODE:  r_turn_mode  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // State vector, kept across evaluations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STATE_SIZE; k++) begin
                r_x[k] <= '0;
            end
        end else if (x_en) begin
            r_x[x_wr_idx] <= i_value;
        end
    end

    assign x_val = r_x[op.xidx];

    qsfp_coef_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (coef)
    );

    qsfp_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_wheel_mode (r_wheel_mode),
        .i_turn_mode  (r_turn_mode),
        .i_pipe_empty (pipe_empty),
        .o_busy       (seq_busy),
        .o_op         (op),
        .o_rd_addr    (rd_addr),
        .o_cap        (cap)
    );

    qsfp_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_x          (x_val),
        .i_coef       (coef),
        .o_acc        (acc),
        .o_pipe_empty (pipe_empty)
    );

    // Result capture; the strobe follows the turntable policy
    assign cap_drive = cap.zero ? '0 : to_drive(acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= cap.capture && cap.pol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap.capture && !cap.pol) begin
            r_wheel_drive <= cap_drive;
        end
        if (cap.capture && cap.pol) begin
            r_turn_drive <= cap_drive;
        end
    end

    assign busy              = seq_busy;
    assign o_result_valid    = r_result_valid;
    assign o_wheel_drive     = r_wheel_drive;
    assign o_turntable_drive = r_turn_drive;

endmodule

`default_nettype wire

>>> design/qsfp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module qsfp_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic [qsfp_pkg::KIND_W-1:0]        i_kind,
    input wire logic                               i_target_policy,
    input wire logic [qsfp_pkg::CIDX_W-1:0]        i_coef_index,
    input wire logic [qsfp_pkg::ELEM_W-1:0]        i_element_index,
    input wire logic signed [qsfp_pkg::VAL_W-1:0]  i_value,
    input wire logic                               o_result_valid,
    input wire logic signed [qsfp_pkg::DRIVE_W-1:0] o_wheel_drive,
    input wire logic signed [qsfp_pkg::DRIVE_W-1:0] o_turntable_drive,
    input wire logic                               i_cfg_valid,
    input wire logic                               o_cfg_ready,
    input wire logic [qsfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input wire logic [qsfp_pkg::MODE_W-1:0]        i_cfg_data
);
    import qsfp_pkg::*;

    // Drives stay within minus one to one
    `QSFP_ASSERT(a_drive_range, o_result_valid |-> (o_wheel_drive <= DRIVE_ONE && o_wheel_drive >= -DRIVE_ONE && o_turntable_drive <= DRIVE_ONE && o_turntable_drive >= -DRIVE_ONE), "drive out of range")

    // A result ends an evaluation that held busy
    `QSFP_ASSERT(a_result_after_busy, o_result_valid |-> $past(busy), "result without evaluation")

    // One strobe per evaluation
    `QSFP_ASSERT(a_single_strobe, o_result_valid |=> !o_result_valid, "repeated result strobe")

    // Items that complete no vector leave the block idle
    `QSFP_ASSERT(a_short_item_idle, (start && !busy && (i_kind == KIND_COEF || i_element_index != LAST_ELEM)) |=> !busy, "short item raised busy")

    // The last element starts an evaluation
    `QSFP_ASSERT(a_last_elem_busy, (start && !busy && i_kind == KIND_STATE && i_element_index == LAST_ELEM) |=> busy, "last element did not start evaluation")

endmodule

bind quadratic_state_feedback_policy qsfp_checker u_qsfp_checker (.*);

`default_nettype wire
